[src/pulse_channel_with_sweep_defines.svh]
// Assertion macros for the pulse channel
`ifndef PULSE_CHANNEL_WITH_SWEEP_DEFINES_SVH
`define PULSE_CHANNEL_WITH_SWEEP_DEFINES_SVH
// property holds at every clock edge outside reset
`define PCS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property holds at every clock edge, reset included
`define PCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[src/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants for the pulse channel.
// ----------------------------------------------------------------------------
`default_nettype none
package pcs_pkg;
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_TIMER = 3'd2;
    localparam logic [2:0] OP_LEN   = 3'd3;
    localparam logic [2:0] OP_ENV   = 3'd4;
    localparam logic [2:0] OP_SWEEP = 3'd5;
    localparam logic [2:0] OP_POWER = 3'd6;

    localparam logic [2:0] REG_SWEEP = 3'd0;
    localparam logic [2:0] REG_DUTY  = 3'd1;
    localparam logic [2:0] REG_ENV   = 3'd2;
    localparam logic [2:0] REG_FLO   = 3'd3;
    localparam logic [2:0] REG_CTRL  = 3'd4;

    typedef struct packed {
        logic       start;   // latch request, run the ops done at acceptance
        logic       calc1;   // first sweep calc (trigger / sweep clock)
        logic       calc2;   // second sweep calc after frequency update
        logic       tstep;   // one timer reload iteration
    } pcs_cmd_t;

    typedef struct packed {
        logic       need_calc;  // request needs sweep calc
        logic       need_calc2;
        logic       timer_more; // timer still <= 0, more reloads pending
    } pcs_stat_t;

    function automatic logic duty_bit(input logic [1:0] d, input logic [2:0] s);
        logic [7:0] p;
        case (d)
            2'd0: p = 8'b00000001;
            2'd1: p = 8'b10000001;
            2'd2: p = 8'b10000111;
            default: p = 8'b01111110;
        endcase
        return p[3'd7 - s];
    endfunction
endpackage
`default_nettype wire

[src/pulse_channel_with_sweep.sv]
// ----------------------------------------------------------------------------
// pulse_channel_with_sweep
// Square-wave sound channel with sweep, envelope and length counter.
// ----------------------------------------------------------------------------
// Usage: one request on s_* (opcode, reg_index, write_data, tick_cycles)
// yields one result on m_* (read_data, sample_level, channel_on).
// Requests are taken one at a time; s_ready is high only when idle.
// m_valid rises once the request has passed the CALC1, CALC2 and TIMER
// states. On a timer advance the TIMER state keeps reloading the period
// while the datapath reports the timer still at or below zero.
// A new request is taken only in the idle state, which follows once the
// result is taken.
// The result is held until m_ready; no request is taken meanwhile.
// cfg_valid/cfg_ready write has_sweep (bit 0 of cfg_data); write only
// while idle. cfg_ready is always high.
// Synchronous active-low reset clears all channel state; has_sweep
// resets to one.
// ----------------------------------------------------------------------------
`default_nettype none
module pulse_channel_with_sweep import pcs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_opcode,
    input  wire logic [2:0] s_reg_index,
    input  wire logic [7:0] s_write_data,
    input  wire logic [7:0] s_tick_cycles,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic [3:0]      m_sample_level,
    output logic            m_channel_on
);
    pcs_cmd_t  cmd;
    pcs_stat_t stat;

    assign cfg_ready = 1'b1;

    pcs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    pcs_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_opcode(s_opcode), .s_reg_index(s_reg_index),
        .s_write_data(s_write_data), .s_tick_cycles(s_tick_cycles),
        .cmd(cmd), .stat(stat),
        .m_read_data(m_read_data), .m_sample_level(m_sample_level),
        .m_channel_on(m_channel_on)
    );
endmodule
`default_nettype wire

[src/pcs_ctrl.sv]
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: accepts a request, steps the datapath, presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pulse_channel_with_sweep_defines.svh"
module pcs_ctrl import pcs_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire pcs_stat_t stat,
    output pcs_cmd_t       cmd
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC1 = 3'd1;
    localparam logic [2:0] ST_CALC2 = 3'd2;
    localparam logic [2:0] ST_TIMER = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1: begin
                if (stat.need_calc) begin
                    cmd.calc1 = 1'b1;
                end
                state_next = ST_CALC2;
            end
            ST_CALC2: begin
                if (stat.need_calc2) begin
                    cmd.calc2 = 1'b1;
                end
                state_next = ST_TIMER;
            end
            ST_TIMER: begin
                if (stat.timer_more) begin
                    cmd.tstep = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PCS_ASSERT(a_one_side, aclk, aresetn, !(s_ready && m_valid), "ready and valid together")
    `PCS_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `PCS_ASSERT(a_start_goes, aclk, aresetn, cmd.start |=> (state_reg == ST_CALC1), "bad start")
    `PCS_ASSERT(a_tstep_state, aclk, aresetn, cmd.tstep |-> (state_reg == ST_TIMER), "stray tstep")
endmodule
`default_nettype wire

[src/pcs_datapath.sv]
// ----------------------------------------------------------------------------
// pcs_datapath
// Channel registers, counters, sweep and timer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_datapath import pcs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic [2:0] s_opcode,
    input  wire logic [2:0] s_reg_index,
    input  wire logic [7:0] s_write_data,
    input  wire logic [7:0] s_tick_cycles,
    input  wire pcs_cmd_t   cmd,
    output pcs_stat_t       stat,
    output logic [7:0]      m_read_data,
    output logic [3:0]      m_sample_level,
    output logic            m_channel_on
);
    logic       has_sweep_reg;
    logic [7:0] sweep_reg, duty_reg, env_reg, flo_reg, ctrl_reg;
    logic       en_reg;
    logic [3:0] vol_reg;
    logic [2:0] step_reg;
    logic signed [15:0] ptim_reg;
    logic [6:0] len_reg;
    logic [2:0] etim_reg;
    logic [3:0] stim_reg;
    logic [10:0] shadow_reg;
    logic       sact_reg, ssub_reg;
    logic       calc_reg, calc2_reg;
    logic       tmr_op_reg;
    logic [7:0] rd_reg;

    logic [10:0] freq;
    logic [13:0] period;
    logic [11:0] calc_val;
    logic        dac;
    logic [2:0]  sper, ssh;

    assign freq = {ctrl_reg[2:0], flo_reg};
    assign period = {(12'd2048 - {1'b0, freq}), 2'b00};
    assign dac = (env_reg[7:3] != 5'd0);
    assign sper = sweep_reg[6:4];
    assign ssh = sweep_reg[2:0];
    assign calc_val = sweep_reg[3] ? ({1'b0, shadow_reg} - {1'b0, shadow_reg >> ssh})
                                   : ({1'b0, shadow_reg} + {1'b0, shadow_reg >> ssh});

    assign stat.need_calc = calc_reg;
    assign stat.need_calc2 = calc2_reg;
    // reloads only follow a timer advance
    assign stat.timer_more = tmr_op_reg && (ptim_reg <= 16'sd0);

    assign m_read_data = rd_reg;
    assign m_channel_on = en_reg;
    assign m_sample_level = (en_reg && duty_bit(duty_reg[7:6], step_reg)) ? vol_reg : 4'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_sweep_reg <= 1'b1;
            sweep_reg <= '0; duty_reg <= '0; env_reg <= '0; flo_reg <= '0; ctrl_reg <= '0;
            en_reg <= 1'b0; vol_reg <= '0; step_reg <= '0; ptim_reg <= 16'sd0;
            len_reg <= '0; etim_reg <= '0; stim_reg <= '0; shadow_reg <= '0;
            sact_reg <= 1'b0; ssub_reg <= 1'b0; calc_reg <= 1'b0; calc2_reg <= 1'b0;
            tmr_op_reg <= 1'b0;
            rd_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                has_sweep_reg <= cfg_data;
            end
            if (cmd.start) begin
                rd_reg <= 8'd0;
                calc_reg <= 1'b0;
                calc2_reg <= 1'b0;
                tmr_op_reg <= (s_opcode == OP_TIMER);
                case (s_opcode)
                    OP_WRITE: begin
                        case (s_reg_index)
                            REG_SWEEP: begin
                                sweep_reg <= s_write_data;
                                if (ssub_reg && !s_write_data[3]) en_reg <= 1'b0;
                            end
                            REG_DUTY: begin
                                duty_reg <= s_write_data;
                                len_reg <= 7'd64 - {1'b0, s_write_data[5:0]};
                            end
                            REG_ENV: begin
                                env_reg <= s_write_data;
                                if (s_write_data[7:3] == 5'd0) en_reg <= 1'b0;
                            end
                            REG_FLO: flo_reg <= s_write_data;
                            REG_CTRL: begin
                                ctrl_reg <= s_write_data;
                                if (s_write_data[7]) begin
                                    en_reg <= dac;
                                    if (len_reg == 7'd0) len_reg <= 7'd64;
                                    ptim_reg <= $signed({2'b00,
                                        (12'd2048 - {1'b0, s_write_data[2:0], flo_reg}), 2'b00});
                                    vol_reg <= env_reg[7:4];
                                    etim_reg <= env_reg[2:0];
                                    if (has_sweep_reg) begin
                                        shadow_reg <= {s_write_data[2:0], flo_reg};
                                        stim_reg <= (sper != 3'd0) ? {1'b0, sper} : 4'd8;
                                        sact_reg <= (sper != 3'd0) || (ssh != 3'd0);
                                        ssub_reg <= 1'b0;
                                        calc_reg <= (ssh != 3'd0);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    OP_READ: begin
                        case (s_reg_index)
                            REG_SWEEP: rd_reg <= sweep_reg | 8'h80;
                            REG_DUTY:  rd_reg <= duty_reg | 8'h3F;
                            REG_ENV:   rd_reg <= env_reg;
                            REG_CTRL:  rd_reg <= ctrl_reg | 8'hBF;
                            default:   rd_reg <= 8'hFF;
                        endcase
                    end
                    OP_TIMER: begin
                        ptim_reg <= ptim_reg - $signed({8'd0, s_tick_cycles});
                    end
                    OP_LEN: begin
                        if (ctrl_reg[6] && len_reg != 7'd0) begin
                            len_reg <= len_reg - 7'd1;
                            if (len_reg == 7'd1) en_reg <= 1'b0;
                        end
                    end
                    OP_ENV: begin
                        if (env_reg[2:0] != 3'd0) begin
                            if (etim_reg > 3'd1) begin
                                etim_reg <= etim_reg - 3'd1;
                            end else begin
                                etim_reg <= env_reg[2:0];
                                if (env_reg[3]) begin
                                    if (vol_reg != 4'd15) vol_reg <= vol_reg + 4'd1;
                                end else if (vol_reg != 4'd0) begin
                                    vol_reg <= vol_reg - 4'd1;
                                end
                            end
                        end
                    end
                    OP_SWEEP: begin
                        if (has_sweep_reg) begin
                            if (stim_reg > 4'd1) begin
                                stim_reg <= stim_reg - 4'd1;
                            end else begin
                                stim_reg <= (sper != 3'd0) ? {1'b0, sper} : 4'd8;
                                calc_reg <= sact_reg && (sper != 3'd0);
                                calc2_reg <= sact_reg && (sper != 3'd0);
                            end
                        end
                    end
                    OP_POWER: begin
                        sweep_reg <= '0; duty_reg <= '0; env_reg <= '0;
                        flo_reg <= '0; ctrl_reg <= '0;
                        en_reg <= 1'b0; vol_reg <= '0; step_reg <= '0;
                        ptim_reg <= 16'sd0;
                        sact_reg <= 1'b0; ssub_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.calc1) begin
                if (sweep_reg[3]) ssub_reg <= 1'b1;
                if (calc_val > 12'd2047) begin
                    en_reg <= 1'b0;
                    calc2_reg <= 1'b0;
                end else if (calc2_reg && ssh != 3'd0) begin
                    shadow_reg <= calc_val[10:0];
                    flo_reg <= calc_val[7:0];
                    ctrl_reg[2:0] <= calc_val[10:8];
                end else begin
                    calc2_reg <= 1'b0;
                end
            end
            if (cmd.calc2) begin
                if (sweep_reg[3]) ssub_reg <= 1'b1;
                if (calc_val > 12'd2047) en_reg <= 1'b0;
            end
            if (cmd.tstep) begin
                ptim_reg <= ptim_reg + $signed({2'b00, period});
                step_reg <= step_reg + 3'd1;
            end
        end
    end
endmodule
`default_nettype wire

[test/pcs_checker.sv]
// ----------------------------------------------------------------------------
// pcs_checker
// Watches the request and result channels of the pulse channel, predicts
// each result from its own model of the channel state and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_checker import pcs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [2:0] s_opcode,
    input  wire logic [2:0] s_reg_index,
    input  wire logic [7:0] s_write_data,
    input  wire logic [7:0] s_tick_cycles,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_read_data,
    input  wire logic [3:0] m_sample_level,
    input  wire logic       m_channel_on,
    output int              fail_count,
    output int              pending
);
    typedef struct packed {
        logic [7:0] rd;
        logic [3:0] level;
        logic       on;
    } chan_out_t;

    chan_out_t  due_q[$];

    logic       sweep_en;
    logic [7:0] r_sweep, r_duty, r_env, r_flo, r_ctrl;
    logic       on;
    logic [3:0] vol;
    logic [2:0] step;
    int         ptimer;
    int         len_cnt;
    int         env_tmr;
    int         swp_tmr;
    int         shadow;
    logic       swp_act, swp_sub;

    assign pending = due_q.size();

    function automatic int freq_now();
        return {r_ctrl[2:0], r_flo};
    endfunction

    function automatic int period_now();
        return (2048 - freq_now()) * 4;
    endfunction

    function automatic int sweep_next();
        int delta;
        delta = shadow >> r_sweep[2:0];
        if (r_sweep[3]) begin
            swp_sub = 1'b1;
            return shadow - delta;
        end
        return shadow + delta;
    endfunction

    task automatic trigger_chan();
        int per;
        on = (r_env[7:3] != 0);
        if (len_cnt == 0) len_cnt = 64;
        ptimer = period_now();
        vol = r_env[7:4];
        env_tmr = r_env[2:0];
        if (sweep_en) begin
            per = r_sweep[6:4];
            shadow = freq_now();
            swp_tmr = (per != 0) ? per : 8;
            swp_act = (per != 0 || r_sweep[2:0] != 0);
            swp_sub = 1'b0;
            if (r_sweep[2:0] != 0 && sweep_next() > 2047) on = 1'b0;
        end
    endtask

    task automatic clear_regs();
        r_sweep = 0; r_duty = 0; r_env = 0; r_flo = 0; r_ctrl = 0;
        on = 0; vol = 0; step = 0; ptimer = 0; swp_act = 0; swp_sub = 0;
    endtask

    task automatic apply_request(input logic [2:0] op, input logic [2:0] idx,
                                 input logic [7:0] d, input logic [7:0] cyc);
        chan_out_t res;
        int        t, p, n, per, nxt;
        res = '0;
        case (op)
            OP_WRITE: begin
                case (idx)
                    REG_SWEEP: begin
                        r_sweep = d;
                        if (swp_sub && !d[3]) on = 1'b0;
                    end
                    REG_DUTY: begin
                        r_duty = d;
                        len_cnt = 64 - d[5:0];
                    end
                    REG_ENV: begin
                        r_env = d;
                        if (d[7:3] == 0) on = 1'b0;
                    end
                    REG_FLO: r_flo = d;
                    REG_CTRL: begin
                        r_ctrl = d;
                        if (d[7]) trigger_chan();
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                case (idx)
                    REG_SWEEP: res.rd = r_sweep | 8'h80;
                    REG_DUTY:  res.rd = r_duty | 8'h3F;
                    REG_ENV:   res.rd = r_env;
                    REG_CTRL:  res.rd = r_ctrl | 8'hBF;
                    default:   res.rd = 8'hFF;
                endcase
            end
            OP_TIMER: begin
                t = ptimer - cyc;
                if (t <= 0) begin
                    p = period_now();
                    n = (-t) / p + 1;
                    t += n * p;
                    step = step + n[2:0];
                end
                ptimer = t;
            end
            OP_LEN: begin
                if (r_ctrl[6] && len_cnt != 0) begin
                    len_cnt--;
                    if (len_cnt == 0) on = 1'b0;
                end
            end
            OP_ENV: begin
                per = r_env[2:0];
                if (per != 0) begin
                    if (env_tmr > 0) env_tmr--;
                    if (env_tmr == 0) begin
                        env_tmr = per;
                        if (r_env[3]) begin
                            if (vol < 15) vol++;
                        end else if (vol > 0) vol--;
                    end
                end
            end
            OP_SWEEP: begin
                if (sweep_en) begin
                    if (swp_tmr > 0) swp_tmr--;
                    if (swp_tmr == 0) begin
                        per = r_sweep[6:4];
                        swp_tmr = (per != 0) ? per : 8;
                        if (swp_act && per != 0) begin
                            nxt = sweep_next();
                            if (nxt > 2047) on = 1'b0;
                            else if (r_sweep[2:0] != 0) begin
                                shadow = nxt;
                                r_flo = nxt[7:0];
                                r_ctrl[2:0] = nxt[10:8];
                                if (sweep_next() > 2047) on = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_POWER: clear_regs();
            default: ;
        endcase
        res.on = on;
        if (on && duty_bit(r_duty[7:6], step)) res.level = vol;
        due_q.push_back(res);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        chan_out_t w;
        if (!aresetn) begin
            sweep_en = 1'b1;
            clear_regs();
            len_cnt = 0; env_tmr = 0; swp_tmr = 0; shadow = 0;
            due_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) sweep_en = cfg_data;
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    w = due_q.pop_front();
                    if (m_read_data !== w.rd) report("read_data", m_read_data, w.rd);
                    if (m_sample_level !== w.level)
                        report("sample_level", m_sample_level, w.level);
                    if (m_channel_on !== w.on) report("channel_on", m_channel_on, w.on);
                end
            end
            if (s_valid && s_ready)
                apply_request(s_opcode, s_reg_index, s_write_data, s_tick_cycles);
        end
    end
endmodule
`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives directed then random requests into the pulse channel under varied
// idling, sweep enable on and off, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
`default_nettype none
module tb import pcs_pkg::*; ();

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid, cfg_ready, cfg_data;
    logic       s_valid, s_ready;
    logic [2:0] s_opcode, s_reg_index;
    logic [7:0] s_write_data, s_tick_cycles;
    logic       m_valid, m_ready;
    logic [7:0] m_read_data;
    logic [3:0] m_sample_level;
    logic       m_channel_on;
    int         fail_count, pending;
    int         src_idle, snk_stall;
    int         cycles;
    bit         hold_off;

    pulse_channel_with_sweep u_dut (.*);

    pcs_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 400000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side stalling
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = !hold_off && ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic send(input logic [2:0] op, input logic [2:0] idx,
                        input logic [7:0] d, input logic [7:0] cyc);
        while ($urandom_range(99) < src_idle) @(negedge aclk);
        s_valid = 1'b1;
        s_opcode = op; s_reg_index = idx; s_write_data = d; s_tick_cycles = cyc;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic set_sweep(input logic v);
        drain();
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random request, mostly well-formed triggers and clocks
    task automatic rand_req();
        int         k;
        logic [7:0] d;
        k = $urandom_range(99);
        d = 8'($urandom);
        if (k < 8) send(OP_WRITE, REG_CTRL, d | 8'h80, 0);
        else if (k < 30) send(OP_WRITE, 3'($urandom_range(4)), d, 0);
        else if (k < 38) send(OP_READ, 3'($urandom_range(7)), d, 8'($urandom));
        else if (k < 55) send(OP_TIMER, 3'($urandom), d, 8'($urandom));
        else if (k < 67) send(OP_LEN, 3'($urandom), d, 8'($urandom));
        else if (k < 79) send(OP_ENV, 3'($urandom), d, 8'($urandom));
        else if (k < 93) send(OP_SWEEP, 3'($urandom), d, 8'($urandom));
        else if (k < 95) send(OP_POWER, 3'($urandom), d, 8'($urandom));
        else if (k < 97) send(3'd7, 3'($urandom), d, 8'($urandom));
        else send(OP_WRITE, 3'($urandom_range(5, 7)), d, 8'($urandom));
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_data = 1'b0;
        s_valid = 1'b0; s_opcode = '0; s_reg_index = '0;
        s_write_data = '0; s_tick_cycles = '0;
        src_idle = 0; snk_stall = 0; hold_off = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed
        send(OP_TIMER, 0, 0, 0);
        send(OP_WRITE, REG_ENV, 8'hF3, 0);
        send(OP_WRITE, REG_DUTY, 8'hBF, 0);
        send(OP_WRITE, REG_FLO, 8'hFF, 0);
        send(OP_WRITE, REG_SWEEP, 8'h19, 0);
        send(OP_WRITE, REG_CTRL, 8'hC7, 0);
        send(OP_TIMER, 0, 0, 8'hFF);
        send(OP_SWEEP, 0, 0, 0);
        send(OP_WRITE, REG_SWEEP, 8'h11, 0);
        send(OP_WRITE, REG_FLO, 8'h00, 0);
        send(OP_WRITE, REG_CTRL, 8'hC0, 0);
        send(OP_TIMER, 0, 0, 8'hFF);
        send(OP_ENV, 0, 0, 0);
        send(OP_LEN, 0, 0, 0);
        for (int i = 0; i < 8; i++) send(OP_READ, 3'(i), 0, 0);
        send(OP_WRITE, REG_ENV, 8'h08, 0);
        send(3'd7, 3'd7, 8'hFF, 8'hFF);
        send(OP_POWER, 0, 0, 0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 51; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 51; end
                default: begin src_idle = 27; snk_stall = 27; end
            endcase
            if (ph == 2 || ph == 5) set_sweep(ph == 2 ? 1'b0 : 1'b1);
            if (ph == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                    repeat (10) rand_req();
                join
                drain();
            end
            repeat (110) rand_req();
        end

        drain();
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+src
src/pcs_pkg.sv
src/pcs_ctrl.sv
src/pcs_datapath.sv
src/pulse_channel_with_sweep.sv
test/pcs_checker.sv
test/tb.sv
